### hdl/ipsp_pkg.sv
// Shared types and constants of the IPS patch stream parser.
// Used by the front, queue, back and checker files; depends on nothing.
`default_nettype none

package ipsp_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_FAIL   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY_ROM = 3'd1,
    ERR_HEADER    = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_BOUNDS    = 3'd4
  } err_t;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_OFFSET = 7'b0000010,
    PH_SIZE   = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_RUNLEN = 7'b0010000,
    PH_RUNVAL = 7'b0100000,
    PH_HALT   = 7'b1000000
  } phase_t;

  localparam logic [23:0] EOF_MARK = 24'h454F46;
  localparam logic [2:0] HEADER_LEN = 3'd5;

  typedef struct packed {
    kind_t       kind;
    logic [24:0] address;
    logic [15:0] run_length;
    logic [7:0]  data_value;
    err_t        error_code;
  } result_t;

  // One queue entry holds everything that one input beat causes: an optional
  // primary result and an optional trailing failure.
  typedef struct packed {
    logic    pri_valid;
    result_t pri;
    logic    sec_valid;
    err_t    sec_err;
  } entry_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd0: b = 8'h50;
      3'd1: b = 8'h41;
      3'd2: b = 8'h54;
      3'd3: b = 8'h43;
      3'd4: b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/ipsp_front.sv
// Front part: accepts patch beats, runs the record parser and builds queue entries.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       patch_byte,
  input  wire logic             last_byte,
  input  wire logic             config_write,
  input  wire logic [26:0]      config_data,
  output logic                  push,
  output ipsp_pkg::entry_t      entry
);

  ipsp_pkg::phase_t phase, phase_next;
  logic [2:0]  idx, idx_next;
  logic [23:0] record_offset, record_offset_next;
  logic [15:0] record_size, record_size_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [24:0] write_pointer, write_pointer_next;
  logic [26:0] rom_bytes;

  logic [23:0] offset_shift;
  logic [15:0] size_shift;
  logic [15:0] addend;
  logic [24:0] bound_sum;
  logic        over;

  assign offset_shift = {record_offset[15:0], patch_byte};
  assign size_shift   = {record_size[7:0], patch_byte};
  assign addend       = (phase == ipsp_pkg::PH_SIZE) ? size_shift : bytes_left;
  assign bound_sum    = {1'b0, record_offset} + {9'b0, addend};
  assign over         = {2'b00, bound_sum} > rom_bytes;

  always_comb begin
    phase_next         = phase;
    idx_next           = idx;
    record_offset_next = record_offset;
    record_size_next   = record_size;
    bytes_left_next    = bytes_left;
    write_pointer_next = write_pointer;
    entry              = '0;
    entry.pri.kind       = ipsp_pkg::KIND_WRITE;
    entry.pri.error_code = ipsp_pkg::ERR_NONE;
    entry.sec_err        = ipsp_pkg::ERR_NONE;

    case (phase)
      ipsp_pkg::PH_HEADER: begin
        if (idx >= ipsp_pkg::HEADER_LEN || patch_byte != ipsp_pkg::magic_byte(idx)) begin
          phase_next           = ipsp_pkg::PH_HALT;
          entry.pri_valid      = 1'b1;
          entry.pri.kind       = ipsp_pkg::KIND_FAIL;
          entry.pri.error_code = ipsp_pkg::ERR_HEADER;
        end else if (idx == ipsp_pkg::HEADER_LEN - 3'd1) begin
          idx_next = 3'd0;
          if (rom_bytes == 27'd0) begin
            phase_next           = ipsp_pkg::PH_HALT;
            entry.pri_valid      = 1'b1;
            entry.pri.kind       = ipsp_pkg::KIND_FAIL;
            entry.pri.error_code = ipsp_pkg::ERR_EMPTY_ROM;
          end else begin
            phase_next = ipsp_pkg::PH_OFFSET;
          end
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      ipsp_pkg::PH_OFFSET: begin
        record_offset_next = offset_shift;
        if (idx >= 3'd2) begin
          idx_next = 3'd0;
          if (offset_shift == ipsp_pkg::EOF_MARK) begin
            phase_next      = ipsp_pkg::PH_HALT;
            entry.pri_valid = 1'b1;
            entry.pri.kind  = ipsp_pkg::KIND_FINISH;
          end else begin
            record_size_next = 16'd0;
            phase_next       = ipsp_pkg::PH_SIZE;
          end
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      ipsp_pkg::PH_SIZE: begin
        record_size_next = size_shift;
        if (idx >= 3'd1) begin
          idx_next = 3'd0;
          if (size_shift == 16'd0) begin
            bytes_left_next = 16'd0;
            phase_next      = ipsp_pkg::PH_RUNLEN;
          end else if (over) begin
            phase_next           = ipsp_pkg::PH_HALT;
            entry.pri_valid      = 1'b1;
            entry.pri.kind       = ipsp_pkg::KIND_FAIL;
            entry.pri.error_code = ipsp_pkg::ERR_BOUNDS;
          end else begin
            bytes_left_next    = size_shift;
            write_pointer_next = {1'b0, record_offset};
            phase_next         = ipsp_pkg::PH_DATA;
          end
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      ipsp_pkg::PH_DATA: begin
        entry.pri_valid      = 1'b1;
        entry.pri.kind       = ipsp_pkg::KIND_WRITE;
        entry.pri.address    = write_pointer;
        entry.pri.data_value = patch_byte;
        write_pointer_next   = write_pointer + 25'd1;
        bytes_left_next      = bytes_left - 16'd1;
        if (bytes_left == 16'd1) begin
          record_offset_next = 24'd0;
          phase_next         = ipsp_pkg::PH_OFFSET;
        end
      end
      ipsp_pkg::PH_RUNLEN: begin
        bytes_left_next = {bytes_left[7:0], patch_byte};
        if (idx >= 3'd1) begin
          idx_next   = 3'd0;
          phase_next = ipsp_pkg::PH_RUNVAL;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      ipsp_pkg::PH_RUNVAL: begin
        if (over) begin
          phase_next           = ipsp_pkg::PH_HALT;
          entry.pri_valid      = 1'b1;
          entry.pri.kind       = ipsp_pkg::KIND_FAIL;
          entry.pri.error_code = ipsp_pkg::ERR_BOUNDS;
        end else begin
          if (bytes_left != 16'd0) begin
            entry.pri_valid      = 1'b1;
            entry.pri.kind       = ipsp_pkg::KIND_FILL;
            entry.pri.address    = {1'b0, record_offset};
            entry.pri.run_length = bytes_left;
            entry.pri.data_value = patch_byte;
          end
          record_offset_next = 24'd0;
          phase_next         = ipsp_pkg::PH_OFFSET;
        end
      end
      default: begin
        phase_next = ipsp_pkg::PH_HALT;
      end
    endcase

    if (last_byte) begin
      if (phase_next == ipsp_pkg::PH_HEADER) begin
        entry.sec_valid = 1'b1;
        entry.sec_err   = ipsp_pkg::ERR_HEADER;
      end else if (phase_next != ipsp_pkg::PH_HALT) begin
        entry.sec_valid = 1'b1;
        entry.sec_err   = ipsp_pkg::ERR_TRUNCATED;
      end
      phase_next         = ipsp_pkg::PH_HEADER;
      idx_next           = 3'd0;
      record_offset_next = 24'd0;
      record_size_next   = 16'd0;
      bytes_left_next    = 16'd0;
      write_pointer_next = 25'd0;
    end
  end

  assign push = accept && (entry.pri_valid || entry.sec_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ipsp_pkg::PH_HEADER;
      idx           <= 3'd0;
      record_offset <= 24'd0;
      record_size   <= 16'd0;
      bytes_left    <= 16'd0;
      write_pointer <= 25'd0;
      rom_bytes     <= 27'd0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        idx           <= idx_next;
        record_offset <= record_offset_next;
        record_size   <= record_size_next;
        bytes_left    <= bytes_left_next;
        write_pointer <= write_pointer_next;
      end
      if (config_write) begin
        rom_bytes <= config_data;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ipsp_queue.sv
// Short register queue of parser entries between the front and back parts.
// Depends on ipsp_pkg. DEPTH must be at least 2.
`default_nettype none

module ipsp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ipsp_pkg::entry_t din,
  input  wire logic             pop,
  output ipsp_pkg::entry_t      dout,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipsp_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ipsp_back.sv
// Back part: expands queue entries into result beats held in the output register.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ipsp_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output ipsp_pkg::result_t     res,
  output logic                  res_last
);

  logic pri_done;
  logic load;
  logic take_pri;

  assign load     = !out_valid || !out_stall;
  assign take_pri = head.pri_valid && !pri_done;
  assign pop      = load && !empty && (!take_pri || !head.sec_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pri_done  <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        pri_done <= take_pri && head.sec_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (take_pri) begin
        res      <= head.pri;
        res_last <= !head.sec_valid;
      end else begin
        res      <= '{kind: ipsp_pkg::KIND_FAIL, address: 25'd0, run_length: 16'd0,
                      data_value: 8'd0, error_code: head.sec_err};
        res_last <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ips_patch_stream_parser.sv
// Top level of the IPS patch stream parser: front parser, entry queue, result back end.
// Depends on ipsp_pkg, ipsp_front, ipsp_queue and ipsp_back.
//
//   channel  | handshake            | payload
//   input    | in_valid / in_stall  | patch_byte, last_byte
//   output   | out_valid / out_stall| kind, address, run_length, data_value,
//            |                      | error_code, last_result
//   config   | config_write         | config_data (ROM size in bytes)
//
// One patch byte is accepted every cycle while the entry queue has room.
// A byte that causes two results holds its entry at the queue head while the back
// end emits both; the queue absorbs it. Results are registered from the queue head
// into the output register. Reset is synchronous and clears the ROM size to zero;
// there is no clearing pass. in_stall rises only when the queue is full.
`default_nettype none

module ips_patch_stream_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        config_write,
  input  wire logic [26:0] config_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  patch_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [24:0]      address,
  output logic [15:0]      run_length,
  output logic [7:0]       data_value,
  output logic [2:0]       error_code,
  output logic             last_result
);

  logic              accept;
  logic              push, pop, full, empty;
  ipsp_pkg::entry_t  entry, head;
  ipsp_pkg::result_t res;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ipsp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .patch_byte   (patch_byte),
    .last_byte    (last_byte),
    .config_write (config_write),
    .config_data  (config_data),
    .push         (push),
    .entry        (entry)
  );

  ipsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  ipsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res),
    .res_last  (last_result)
  );

  assign kind       = res.kind;
  assign address    = res.address;
  assign run_length = res.run_length;
  assign data_value = res.data_value;
  assign error_code = res.error_code;

endmodule

`default_nettype wire

### hdl/ipsp_checker.sv
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on ipsp_pkg and ips_patch_stream_parser.
`default_nettype none

module ipsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  kind,
  input wire logic [24:0] address,
  input wire logic [15:0] run_length,
  input wire logic [7:0]  data_value,
  input wire logic [2:0]  error_code,
  input wire logic        last_result
);

  localparam logic [1:0] K_FILL   = ipsp_pkg::KIND_FILL;
  localparam logic [1:0] K_FINISH = ipsp_pkg::KIND_FINISH;
  localparam logic [1:0] K_FAIL   = ipsp_pkg::KIND_FAIL;
  localparam logic [2:0] E_NONE   = ipsp_pkg::ERR_NONE;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(address)
      && $stable(data_value) && $stable(error_code) && $stable(last_result))
    else $error("stalled result beat changed");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == K_FAIL) == (error_code != E_NONE)))
    else $error("error code does not match result kind");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == K_FINISH || kind == K_FAIL) |-> last_result
      && address == 25'd0 && data_value == 8'd0)
    else $error("finish or fail beat is not a clean final result");

  a_fill_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == K_FILL) == (run_length != 16'd0)))
    else $error("run length does not match fill kind");

endmodule

bind ips_patch_stream_parser ipsp_checker u_checker (.*);

`default_nettype wire

### tb/sv/ips_patch_stream_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the IPS patch stream parser: directed patches, back-pressure
// and random patch streams, each result checked against a behavioral predictor of the parser.
// Depends on ipsp_pkg and ips_patch_stream_parser.
module ips_patch_stream_parser_tb;

  localparam int LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 250;
  localparam int TOTAL_BEATS = 1750;
  localparam int CALM_BEATS = 300;
  localparam logic [39:0] SIGNATURE = "PATCH";
  localparam logic [26:0] ROM_MAX = 27'd67108864;

  typedef struct packed {
    ipsp_pkg::kind_t kind;
    logic [24:0]     address;
    logic [15:0]     run_length;
    logic [7:0]      data_value;
    ipsp_pkg::err_t  error_code;
    logic            last_result;
  } rom_command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic config_write = 1'b0;
  logic [26:0] config_data = '0;
  logic in_valid = 1'b0;
  logic [7:0] patch_byte = '0;
  logic last_byte = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [1:0] kind;
  logic [24:0] address;
  logic [15:0] run_length;
  logic [7:0] data_value;
  logic [2:0] error_code;
  logic last_result;

  rom_command_t rom_commands_due[$];
  rom_command_t oldest_command;
  logic [7:0] patch_bytes[$];

  ipsp_pkg::phase_t pr_phase = ipsp_pkg::PH_HEADER;
  logic [2:0] pr_index = '0;
  logic [23:0] pr_offset = '0;
  logic [15:0] pr_size = '0;
  logic [15:0] pr_left = '0;
  logic [24:0] pr_wptr = '0;
  logic [26:0] pr_rom_bytes = '0;

  bit idle_on = 1'b1;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int results_checked = 0;
  int beats_sent = 0;
  int patches_sent = 0;
  int rom_settings = 0;
  int input_stall_cycles = 0;

  ips_patch_stream_parser DUT (
    .clk(clk),
    .rst(rst),
    .config_write(config_write),
    .config_data(config_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .patch_byte(patch_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .address(address),
    .run_length(run_length),
    .data_value(data_value),
    .error_code(error_code),
    .last_result(last_result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               rom_commands_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
    end else begin
      burst_left <= $urandom_range(1, 17);
      out_stall <= idle_on && ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) input_stall_cycles <= input_stall_cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      results_checked <= results_checked + 1;
      if (rom_commands_due.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected result: kind %0d address %h length %h value %h error %0d",
                   kind, address, run_length, data_value, error_code);
        mismatches <= mismatches + 1;
      end else begin
        oldest_command = rom_commands_due.pop_front();
        if (kind !== oldest_command.kind || address !== oldest_command.address ||
            run_length !== oldest_command.run_length ||
            data_value !== oldest_command.data_value ||
            error_code !== oldest_command.error_code ||
            last_result !== oldest_command.last_result) begin
          if (mismatches < 10) begin
            $display("Mismatch (expected/actual): kind %0d/%0d address %h/%h length %h/%h",
                     oldest_command.kind, kind, oldest_command.address, address,
                     oldest_command.run_length, run_length);
            $display("  value %h/%h error %0d/%0d last %0b/%0b",
                     oldest_command.data_value, data_value, oldest_command.error_code,
                     error_code, oldest_command.last_result, last_result);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  function automatic void queue_command(input ipsp_pkg::kind_t k, input logic [24:0] a,
                                        input logic [15:0] len, input logic [7:0] v,
                                        input ipsp_pkg::err_t e);
    rom_command_t c;
    c.kind = k;
    c.address = a;
    c.run_length = len;
    c.data_value = v;
    c.error_code = e;
    c.last_result = 1'b0;
    rom_commands_due.push_back(c);
  endfunction

  function automatic void abort_patch(input ipsp_pkg::err_t e);
    pr_phase = ipsp_pkg::PH_HALT;
    queue_command(ipsp_pkg::KIND_FAIL, '0, '0, '0, e);
  endfunction

  function automatic logic record_out_of_bounds(input logic [15:0] len);
    return (28'(pr_offset) + 28'(len)) > 28'(pr_rom_bytes);
  endfunction

  function automatic void parse_patch_byte(input logic [7:0] b, input logic lst);
    int n_before;
    int i;
    rom_command_t c;
    n_before = rom_commands_due.size();
    i = pr_index;
    case (pr_phase)
      ipsp_pkg::PH_HEADER: begin
        if (pr_index >= ipsp_pkg::HEADER_LEN || b != SIGNATURE[39 - 8 * i -: 8]) begin
          abort_patch(ipsp_pkg::ERR_HEADER);
        end else begin
          pr_index = pr_index + 3'd1;
          if (pr_index == ipsp_pkg::HEADER_LEN) begin
            pr_index = '0;
            if (pr_rom_bytes == '0) abort_patch(ipsp_pkg::ERR_EMPTY_ROM);
            else pr_phase = ipsp_pkg::PH_OFFSET;
          end
        end
      end
      ipsp_pkg::PH_OFFSET: begin
        pr_offset = {pr_offset[15:0], b};
        pr_index = pr_index + 3'd1;
        if (pr_index >= 3'd3) begin
          pr_index = '0;
          if (pr_offset == ipsp_pkg::EOF_MARK) begin
            pr_phase = ipsp_pkg::PH_HALT;
            queue_command(ipsp_pkg::KIND_FINISH, '0, '0, '0, ipsp_pkg::ERR_NONE);
          end else begin
            pr_size = '0;
            pr_phase = ipsp_pkg::PH_SIZE;
          end
        end
      end
      ipsp_pkg::PH_SIZE: begin
        pr_size = {pr_size[7:0], b};
        pr_index = pr_index + 3'd1;
        if (pr_index >= 3'd2) begin
          pr_index = '0;
          if (pr_size == '0) begin
            pr_left = '0;
            pr_phase = ipsp_pkg::PH_RUNLEN;
          end else if (record_out_of_bounds(pr_size)) begin
            abort_patch(ipsp_pkg::ERR_BOUNDS);
          end else begin
            pr_left = pr_size;
            pr_wptr = 25'(pr_offset);
            pr_phase = ipsp_pkg::PH_DATA;
          end
        end
      end
      ipsp_pkg::PH_DATA: begin
        queue_command(ipsp_pkg::KIND_WRITE, pr_wptr, '0, b, ipsp_pkg::ERR_NONE);
        pr_wptr = pr_wptr + 25'd1;
        pr_left = pr_left - 16'd1;
        if (pr_left == '0) begin
          pr_offset = '0;
          pr_phase = ipsp_pkg::PH_OFFSET;
        end
      end
      ipsp_pkg::PH_RUNLEN: begin
        pr_left = {pr_left[7:0], b};
        pr_index = pr_index + 3'd1;
        if (pr_index >= 3'd2) begin
          pr_index = '0;
          pr_phase = ipsp_pkg::PH_RUNVAL;
        end
      end
      ipsp_pkg::PH_RUNVAL: begin
        if (record_out_of_bounds(pr_left)) begin
          abort_patch(ipsp_pkg::ERR_BOUNDS);
        end else begin
          if (pr_left != '0)
            queue_command(ipsp_pkg::KIND_FILL, 25'(pr_offset), pr_left, b,
                          ipsp_pkg::ERR_NONE);
          pr_offset = '0;
          pr_phase = ipsp_pkg::PH_OFFSET;
        end
      end
      default: pr_phase = ipsp_pkg::PH_HALT;
    endcase
    if (lst) begin
      if (pr_phase == ipsp_pkg::PH_HEADER) abort_patch(ipsp_pkg::ERR_HEADER);
      else if (pr_phase != ipsp_pkg::PH_HALT) abort_patch(ipsp_pkg::ERR_TRUNCATED);
      pr_phase = ipsp_pkg::PH_HEADER;
      pr_index = '0;
      pr_offset = '0;
      pr_size = '0;
      pr_left = '0;
      pr_wptr = '0;
    end
    if (rom_commands_due.size() > n_before) begin
      c = rom_commands_due.pop_back();
      c.last_result = 1'b1;
      rom_commands_due.push_back(c);
    end
  endfunction

  task automatic send_patch_byte(input logic [7:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    patch_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_patch_byte(b, lst);
    beats_sent++;
  endtask

  task automatic send_patch();
    foreach (patch_bytes[i]) send_patch_byte(patch_bytes[i], i == patch_bytes.size() - 1);
    patch_bytes.delete();
    patches_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rom_commands_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_rom_bytes(input logic [26:0] v);
    wait_drained();
    config_write <= 1'b1;
    config_data <= v;
    @(posedge clk);
    config_write <= 1'b0;
    pr_rom_bytes = v;
    rom_settings++;
  endtask

  function automatic void put_header();
    for (int i = 0; i < 5; i++) patch_bytes.push_back(SIGNATURE[39 - 8 * i -: 8]);
  endfunction

  function automatic void put_be(input logic [23:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) patch_bytes.push_back(v[8 * i +: 8]);
  endfunction

  function automatic logic [23:0] pick_offset(input int unsigned len);
    int unsigned span;
    span = (pr_rom_bytes > len) ? pr_rom_bytes - len : 0;
    if (span > 32'hFFFFFF) span = 32'hFFFFFF;
    case ($urandom_range(0, 15))
      0: return 24'($urandom);
      1: return 24'(span);
      2: return 24'hFFFFFF - 24'($urandom_range(0, 7));
      default: return 24'($urandom_range(0, span));
    endcase
  endfunction

  task automatic test_empty_rom();
    put_header();
    send_patch();
  endtask

  task automatic test_header_errors();
    set_rom_bytes(27'd1);
    put_be(24'h50, 1);
    put_be(24'h58, 1);
    put_be(24'hA7, 1);
    send_patch();
    put_be(24'h5041, 2);
    send_patch();
  endtask

  task automatic test_records();
    set_rom_bytes(27'd16);
    put_header();
    put_be(24'd14, 3);
    put_be(24'd2, 2);
    put_be(24'h00, 1);
    put_be(24'hFF, 1);
    put_be(24'd16, 3);
    put_be(24'd0, 2);
    put_be(24'd0, 2);
    put_be(24'h5A, 1);
    put_be(24'd0, 3);
    put_be(24'd0, 2);
    put_be(24'd16, 2);
    put_be(24'hA5, 1);
    put_be(ipsp_pkg::EOF_MARK, 3);
    put_be(24'h3C, 1);
    send_patch();
  endtask

  task automatic test_bounds();
    put_header();
    put_be(24'd15, 3);
    put_be(24'd2, 2);
    put_be(24'h81, 1);
    send_patch();
    put_header();
    put_be(24'd17, 3);
    put_be(24'd0, 2);
    put_be(24'd0, 2);
    put_be(24'h00, 1);
    send_patch();
  endtask

  task automatic test_truncation();
    set_rom_bytes(ROM_MAX);
    put_header();
    put_be(24'hFFFFFF, 3);
    put_be(24'd3, 2);
    put_be(24'h1122, 2);
    send_patch();
    put_header();
    send_patch();
  endtask

  task automatic test_backpressure();
    idle_on <= 1'b0;
    hold_request <= hold_request + 1;
    put_header();
    put_be(24'h000100, 3);
    put_be(24'd40, 2);
    repeat (40) put_be(24'($urandom_range(0, 255)), 1);
    put_be(ipsp_pkg::EOF_MARK, 3);
    foreach (patch_bytes[i]) begin
      if (i == 30) wait_drained();
      send_patch_byte(patch_bytes[i], i == patch_bytes.size() - 1);
    end
    patch_bytes.delete();
    patches_sent++;
    wait_drained();
    idle_on <= 1'b1;
  endtask

  task automatic test_random_patches();
    int unsigned len;
    int pick;
    int cut;
    int nrec;
    while (beats_sent < TOTAL_BEATS) begin
      if (TOTAL_BEATS - beats_sent < CALM_BEATS) idle_on <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) set_rom_bytes('0);
        else if (pick == 1) set_rom_bytes(27'd1);
        else if (pick < 6) set_rom_bytes(ROM_MAX);
        else if (pick < 11) set_rom_bytes(27'($urandom_range(16, 4096)));
        else set_rom_bytes(27'($urandom_range(0, ROM_MAX)));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        repeat ($urandom_range(1, 12)) put_be(24'($urandom_range(0, 255)), 1);
      end else if (pick == 1) begin
        put_header();
        cut = $urandom_range(0, 4);
        patch_bytes[cut] = patch_bytes[cut] ^ 8'($urandom_range(1, 255));
        repeat ($urandom_range(0, 4)) put_be(24'($urandom_range(0, 255)), 1);
      end else begin
        put_header();
        nrec = $urandom_range(0, 6);
        repeat (nrec) begin
          if ($urandom_range(0, 4) < 3) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            put_be(pick_offset(len), 3);
            put_be(24'(len), 2);
            repeat (len) put_be(24'($urandom_range(0, 255)), 1);
          end else begin
            case ($urandom_range(0, 3))
              0: len = 0;
              1: len = 16'hFFFF;
              2: len = $urandom_range(1, 16);
              default: len = $urandom_range(0, 65535);
            endcase
            put_be(pick_offset(len), 3);
            put_be(24'd0, 2);
            put_be(24'(len), 2);
            put_be(24'($urandom_range(0, 255)), 1);
          end
        end
        if ($urandom_range(0, 9) != 0) put_be(ipsp_pkg::EOF_MARK, 3);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) put_be(24'($urandom_range(0, 255)), 1);
      end
      if ($urandom_range(0, 6) == 0 && patch_bytes.size() > 1) begin
        cut = $urandom_range(1, patch_bytes.size() - 1);
        patch_bytes = patch_bytes[0:cut - 1];
      end
      send_patch();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_rom();
    test_header_errors();
    test_records();
    test_bounds();
    test_truncation();
    test_backpressure();
    test_random_patches();
    wait_drained();
    $display("Sent %0d beats in %0d patch files under %0d ROM size settings; checked %0d results.",
             beats_sent, patches_sent, rom_settings, results_checked);
    $display("The input was held off for %0d cycles; %0d mismatches were found.",
             input_stall_cycles, mismatches);
    if (mismatches == 0 && rom_commands_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/ipsp_pkg.sv
hdl/ipsp_front.sv
hdl/ipsp_queue.sv
hdl/ipsp_back.sv
hdl/ips_patch_stream_parser.sv
hdl/ipsp_checker.sv
tb/sv/ips_patch_stream_parser_tb.sv
